[hdl/free_list_slot_allocator_top_defines.svh]
// Assertion macros used by the free-list slot allocator top level.
// Needs a clk and an active-low rst_n in the scope of each use.
`ifndef FREE_LIST_SLOT_ALLOCATOR_TOP_DEFINES_SVH
`define FREE_LIST_SLOT_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define FLA_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define FLA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/fla_pkg.sv]
// Shared types and codes for the free-list slot allocator.
// No dependencies; used by fla_link_mem and the top level.
`default_nettype none

package fla_pkg;

    localparam int IDX_W = 8;

    typedef enum logic
    {
        KIND_ALLOC   = 1'b0,
        KIND_RELEASE = 1'b1
    } kind_t;

    typedef enum logic [1:0]
    {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

    typedef enum logic [1:0]
    {
        ST_INIT,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    // Access strobes from the controller into the link memory.
    typedef struct packed
    {
        logic rd_en;
        logic wr_en;
    } link_cmd_t;

endpackage

`default_nettype wire

[hdl/free_list_slot_allocator_top.sv]
// Channel   Dir  tdata               tuser        Meaning
// s_*       in   [7:0] release_index [0] kind     allocate / release request
// m_*       out  [7:0] granted_index [1:0] status one result per request
//
// On an allocate the head slot's link is read from the link memory, and the
// head moves to it the cycle after. Release and rejected requests need no lookup.
// After reset the link chain is written one entry a cycle, with s_tready low
// through the sweep. The result register lets a request be taken while the
// previous result waits, as long as m_tready frees it in the same cycle.
// Depends on fla_pkg, fla_link_mem and the defines header.
`default_nettype none
`include "free_list_slot_allocator_top_defines.svh"

module free_list_slot_allocator_top
#(
    parameter int NUM_SLOTS = 256
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] release_index
    input  wire logic       s_tuser,   // [0] kind
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic      [7:0] m_tdata,   // [7:0] granted_index
    output logic      [1:0] m_tuser    // [1:0] status
);

    localparam int AW = $clog2(NUM_SLOTS);
    localparam int LW = $clog2(NUM_SLOTS + 1);
    localparam int IW = fla_pkg::IDX_W;
    localparam int CW = (LW > IW + 1) ? LW : IW + 1;
    localparam logic [LW-1:0] END_MARK = LW'(NUM_SLOTS);

    fla_pkg::state_t    state_reg;
    fla_pkg::state_t    state_next;
    fla_pkg::link_cmd_t cmd;

    logic [LW-1:0]            head_reg;
    logic [LW-1:0]            head_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    fla_pkg::status_t         out_status_reg;
    fla_pkg::status_t         out_status_next;
    logic [fla_pkg::IDX_W-1:0] out_grant_reg;
    logic [fla_pkg::IDX_W-1:0] out_grant_next;

    logic          accept;
    logic          is_alloc;
    logic          pool_empty;
    logic          in_range;
    logic          init_done;
    logic [LW-1:0] rd_data;
    logic [LW-1:0] link_clamped;

    fla_link_mem #(.NUM_SLOTS(NUM_SLOTS)) u_link_mem
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .rd_addr   (head_reg[AW-1:0]),
        .wr_addr   (AW'(s_tdata)),
        .wr_data   (head_reg),
        .rd_data   (rd_data),
        .init_done (init_done)
    );

    assign accept       = s_tvalid && s_tready;
    assign is_alloc     = (s_tuser == fla_pkg::KIND_ALLOC);
    assign pool_empty   = (head_reg >= END_MARK);
    assign in_range     = (CW'(s_tdata) < CW'(NUM_SLOTS));
    assign link_clamped = (rd_data < END_MARK) ? rd_data : END_MARK;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fla_pkg::ST_INIT:
            begin
                if (init_done)
                begin
                    state_next = fla_pkg::ST_IDLE;
                end
            end
            fla_pkg::ST_IDLE:
            begin
                if (accept && is_alloc && !pool_empty)
                begin
                    state_next = fla_pkg::ST_LOOKUP;
                end
            end
            fla_pkg::ST_LOOKUP:
            begin
                state_next = fla_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = fla_pkg::ST_INIT;
            end
        endcase
    end

    // Outputs and datapath
    always_comb
    begin
        s_tready        = (state_reg == fla_pkg::ST_IDLE) && (!out_valid_reg || m_tready);
        cmd.rd_en       = 1'b0;
        cmd.wr_en       = 1'b0;
        head_next       = head_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_grant_next  = out_grant_reg;

        case (state_reg)
            fla_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = fla_pkg::STATUS_OK;
                    out_grant_next  = '0;
                    if (is_alloc)
                    begin
                        if (pool_empty)
                        begin
                            out_status_next = fla_pkg::STATUS_EMPTY;
                        end
                        else
                        begin
                            // hand out the head now, fetch its link
                            cmd.rd_en      = 1'b1;
                            out_grant_next = IW'(head_reg);
                        end
                    end
                    else if (in_range)
                    begin
                        // push: released slot links to the old head
                        cmd.wr_en = 1'b1;
                        head_next = LW'(s_tdata);
                    end
                    else
                    begin
                        out_status_next = fla_pkg::STATUS_RANGE;
                    end
                end
            end
            fla_pkg::ST_LOOKUP:
            begin
                head_next = link_clamped;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fla_pkg::ST_INIT;
            head_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_grant_reg  <= out_grant_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_grant_reg;
    assign m_tuser  = out_status_reg;

    `FLA_ASSERT_IMPLY(a_ready_needs_init, s_tready, init_done, "request taken during link sweep")
    `FLA_ASSERT_IMPLY(a_head_bounded, 1'b1, head_reg <= END_MARK, "head beyond end marker")
    `FLA_ASSERT_NEXT(a_alloc_lookup, accept && is_alloc && !pool_empty,
        state_reg == fla_pkg::ST_LOOKUP && m_tvalid, "allocate did not enter lookup")
    `FLA_ASSERT_IMPLY(a_fail_no_grant, m_tvalid && m_tuser != fla_pkg::STATUS_OK,
        m_tdata == '0, "grant on failed request")

endmodule

`default_nettype wire

[hdl/fla_link_mem.sv]
// Link memory of the free list, with the chain-building sweep after reset.
// Depends on fla_pkg for the command struct.
`default_nettype none

module fla_link_mem
#(
    parameter int NUM_SLOTS = 256
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire fla_pkg::link_cmd_t                cmd,
    input  wire logic [$clog2(NUM_SLOTS)-1:0]      rd_addr,
    input  wire logic [$clog2(NUM_SLOTS)-1:0]      wr_addr,
    input  wire logic [$clog2(NUM_SLOTS+1)-1:0]    wr_data,
    output logic      [$clog2(NUM_SLOTS+1)-1:0]    rd_data,
    output logic                                   init_done
);

    localparam int AW = $clog2(NUM_SLOTS);
    localparam int LW = $clog2(NUM_SLOTS + 1);

    logic [LW-1:0] link_mem [NUM_SLOTS];
    logic [LW-1:0] rd_data_reg;
    logic [AW-1:0] init_cnt_reg;
    logic [AW-1:0] init_cnt_next;
    logic          init_done_reg;
    logic          init_done_next;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [LW-1:0] mem_wd;

    // Sweep: entry i gets i+1, so the last entry gets the end marker.
    always_comb
    begin
        init_cnt_next  = init_cnt_reg;
        init_done_next = init_done_reg;
        if (!init_done_reg)
        begin
            init_cnt_next = init_cnt_reg + AW'(1);
            if (init_cnt_reg == AW'(NUM_SLOTS - 1))
            begin
                init_done_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        if (!init_done_reg)
        begin
            mem_we = 1'b1;
            mem_wa = init_cnt_reg;
            mem_wd = LW'(init_cnt_reg) + LW'(1);
        end
        else
        begin
            mem_we = cmd.wr_en;
            mem_wa = wr_addr;
            mem_wd = wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_cnt_reg  <= '0;
            init_done_reg <= 1'b0;
        end
        else
        begin
            init_cnt_reg  <= init_cnt_next;
            init_done_reg <= init_done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[mem_wa] <= mem_wd;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= link_mem[rd_addr];
        end
    end

    assign rd_data   = rd_data_reg;
    assign init_done = init_done_reg;

endmodule

`default_nettype wire

[tb/free_list_slot_allocator_top_tb.sv]
// Self-checking testbench for free_list_slot_allocator_top: a stimulus table,
// then drain, refill and mixed phases, checked against a free-list predictor or the table.
// Depends on fla_pkg and the allocator RTL only.
`default_nettype none

module free_list_slot_allocator_top_tb;

    localparam int POOL_SIZE = 256;
    localparam logic [8:0] SLOT_END = 9'(POOL_SIZE);

    typedef struct packed
    {
        fla_pkg::status_t status;
        logic [7:0]       slot;
    } alloc_reply_t;

    typedef struct packed
    {
        fla_pkg::kind_t   kind;
        logic [7:0]       index;
        logic             typed;
        fla_pkg::status_t status;
        logic [7:0]       slot;
    } table_row_t;

    // After reset the pool hands out 0, 1, 2 in order; releases push LIFO.
    localparam table_row_t STIM_TABLE [18] = '{
        '{fla_pkg::KIND_ALLOC,   8'h00, 1'b1, fla_pkg::STATUS_OK, 8'd0},
        '{fla_pkg::KIND_ALLOC,   8'hFF, 1'b1, fla_pkg::STATUS_OK, 8'd1},
        '{fla_pkg::KIND_ALLOC,   8'h5A, 1'b1, fla_pkg::STATUS_OK, 8'd2},
        '{fla_pkg::KIND_RELEASE, 8'h01, 1'b1, fla_pkg::STATUS_OK, 8'd0},
        '{fla_pkg::KIND_ALLOC,   8'h00, 1'b1, fla_pkg::STATUS_OK, 8'd1},
        '{fla_pkg::KIND_RELEASE, 8'h00, 1'b1, fla_pkg::STATUS_OK, 8'd0},
        '{fla_pkg::KIND_RELEASE, 8'h02, 1'b1, fla_pkg::STATUS_OK, 8'd0},
        '{fla_pkg::KIND_ALLOC,   8'hA5, 1'b1, fla_pkg::STATUS_OK, 8'd2},
        '{fla_pkg::KIND_ALLOC,   8'h00, 1'b1, fla_pkg::STATUS_OK, 8'd0},
        '{fla_pkg::KIND_ALLOC,   8'h00, 1'b1, fla_pkg::STATUS_OK, 8'd3},
        '{fla_pkg::KIND_RELEASE, 8'h03, 1'b1, fla_pkg::STATUS_OK, 8'd0},
        '{fla_pkg::KIND_RELEASE, 8'h00, 1'b1, fla_pkg::STATUS_OK, 8'd0},
        '{fla_pkg::KIND_RELEASE, 8'h02, 1'b1, fla_pkg::STATUS_OK, 8'd0},
        '{fla_pkg::KIND_RELEASE, 8'h01, 1'b1, fla_pkg::STATUS_OK, 8'd0},
        '{fla_pkg::KIND_ALLOC,   8'hFF, 1'b0, fla_pkg::STATUS_OK, 8'd0},
        '{fla_pkg::KIND_ALLOC,   8'h00, 1'b0, fla_pkg::STATUS_OK, 8'd0},
        '{fla_pkg::KIND_RELEASE, 8'h02, 1'b0, fla_pkg::STATUS_OK, 8'd0},
        '{fla_pkg::KIND_RELEASE, 8'h01, 1'b0, fla_pkg::STATUS_OK, 8'd0}
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;   // [7:0] release_index
    logic       s_tuser = 1'b0;    // [0] kind
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // [7:0] granted_index
    logic [1:0] m_tuser;           // [1:0] status

    // Predictor state: link memory and head of the free list.
    logic [8:0] slot_link [POOL_SIZE];
    logic [8:0] free_head;

    alloc_reply_t replies_due [$];
    logic [7:0]   held_slots [$];
    int           mismatches = 0;
    bit           src_gaps = 1'b0;
    bit           sink_gaps = 1'b0;
    int           stall_left = 0;

    free_list_slot_allocator_top
    #(
        .NUM_SLOTS (POOL_SIZE)
    )
    u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #1 clk = ~clk;

    initial
    begin
        #1000000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
    endtask

    // Apply one request to the free list and return the reply it earns.
    function automatic alloc_reply_t serve_request(input fla_pkg::kind_t kind,
                                                   input logic [7:0] index);
        alloc_reply_t reply;
        reply.status = fla_pkg::STATUS_OK;
        reply.slot   = 8'd0;
        if (kind == fla_pkg::KIND_ALLOC)
        begin
            if (free_head >= SLOT_END)
                reply.status = fla_pkg::STATUS_EMPTY;
            else
            begin
                reply.slot = free_head[7:0];
                free_head  = (slot_link[free_head[7:0]] < SLOT_END) ?
                             slot_link[free_head[7:0]] : SLOT_END;
            end
        end
        else if ({1'b0, index} >= SLOT_END)
            reply.status = fla_pkg::STATUS_RANGE;
        else
        begin
            slot_link[index] = free_head;
            free_head        = {1'b0, index};
        end
        return reply;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input fla_pkg::kind_t kind, input logic [7:0] index,
                                input logic typed, input fla_pkg::status_t status,
                                input logic [7:0] slot);
        alloc_reply_t reply;
        int           found [$];
        if (src_gaps && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= index;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        reply = serve_request(kind, index);
        if (typed)
        begin
            reply.status = status;
            reply.slot   = slot;
        end
        replies_due.push_back(reply);
        if (kind == fla_pkg::KIND_ALLOC && reply.status == fla_pkg::STATUS_OK)
            held_slots.push_back(reply.slot);
        else if (kind == fla_pkg::KIND_RELEASE)
        begin
            found = held_slots.find_first_index(h) with (h == index);
            if (found.size() != 0)
                held_slots.delete(found[0]);
        end
        @(negedge clk);
    endtask

    task automatic set_idling(input bit allowed);
        src_gaps  = allowed && ($urandom_range(0, 3) != 0);
        sink_gaps = allowed && ($urandom_range(0, 3) != 0);
    endtask

    task automatic alloc_one();
        send_request(fla_pkg::KIND_ALLOC, 8'($urandom), 1'b0, fla_pkg::STATUS_OK, 8'd0);
    endtask

    task automatic release_held();
        send_request(fla_pkg::KIND_RELEASE,
                     held_slots[$urandom_range(0, held_slots.size() - 1)],
                     1'b0, fla_pkg::STATUS_OK, 8'd0);
    endtask

    // Allocate until the pool runs dry, then hit the empty case a few times.
    task automatic drain_pool();
        int count;
        count = 0;
        while (free_head != SLOT_END && count < 400)
        begin
            alloc_one();
            count++;
        end
        repeat ($urandom_range(1, 4)) alloc_one();
    endtask

    task automatic refill_pool();
        while (held_slots.size() != 0)
            release_held();
    endtask

    // Noisy mode also releases arbitrary slots, which may double-release.
    task automatic mixed_traffic(input int count, input bit noisy);
        int pick;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (noisy && pick < 8)
                send_request(fla_pkg::KIND_RELEASE, 8'($urandom), 1'b0,
                             fla_pkg::STATUS_OK, 8'd0);
            else if (pick < 55 || held_slots.size() == 0)
                alloc_one();
            else
                release_held();
        end
    endtask

    always @(negedge clk)
    begin
        if (stall_left != 0 && sink_gaps)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (sink_gaps && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(0, 17);
            m_tready   <= 1'b0;
        end
        else
        begin
            stall_left <= 0;
            m_tready   <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        alloc_reply_t due;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (replies_due.size() == 0)
                report_mismatch("result with no request pending, slot", m_tdata, 0);
            else
            begin
                due = replies_due.pop_front();
                if (m_tuser !== due.status)
                    report_mismatch("status", m_tuser, due.status);
                if (m_tdata !== due.slot)
                    report_mismatch("granted_index", m_tdata, due.slot);
            end
        end
    end

    initial
    begin
        int i;
        for (i = 0; i < POOL_SIZE; i++)
            slot_link[8'(i)] = 9'(i + 1);
        free_head = 9'd0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_idling(1'b1);
        for (i = 0; i < $size(STIM_TABLE); i++)
            send_request(STIM_TABLE[i].kind, STIM_TABLE[i].index, STIM_TABLE[i].typed,
                         STIM_TABLE[i].status, STIM_TABLE[i].slot);

        set_idling(1'b1);
        mixed_traffic(80, 1'b0);
        set_idling(1'b1);
        drain_pool();

        // Hold off until the block has answered every request.
        s_tvalid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
        @(negedge clk);

        set_idling(1'b1);
        refill_pool();
        set_idling(1'b1);
        mixed_traffic(80, 1'b0);
        set_idling(1'b1);
        drain_pool();
        set_idling(1'b1);
        refill_pool();

        // Double releases can loop the list, so keep them to the final stretch.
        set_idling(1'b0);
        mixed_traffic(150, 1'b1);

        s_tvalid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
+incdir+hdl
hdl/fla_pkg.sv
hdl/fla_link_mem.sv
hdl/free_list_slot_allocator_top.sv
tb/free_list_slot_allocator_top_tb.sv
